[sv/sac_pkg.sv]
// sac_pkg: shared widths, command codes and status codes for the stack ALU calculator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package sac_pkg;

    localparam int DATA_W          = 32;
    localparam int FUNC_W          = 3;
    localparam int DEPTH_W         = 8;
    localparam int STATUS_W        = 2;
    localparam int STACK_DEPTH_DEF = 128;

    // stream packing, rounded up to whole bytes
    localparam int S_TDATA_W = ((FUNC_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + DEPTH_W + STATUS_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_ADD  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SUB  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_MUL  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DIV  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIV0 = 2'd3;

endpackage

[sv/sac_stack_ram.sv]
// sac_stack_ram: operand stack storage, one write port and one read port,
// read data registered. Depends on sac_pkg.
`timescale 1ns / 1ps

module sac_stack_ram #(
    parameter int STACK_DEPTH = sac_pkg::STACK_DEPTH_DEF,
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [sac_pkg::DATA_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [sac_pkg::DATA_W-1:0] o_rdata
);

    logic [sac_pkg::DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [sac_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sac_div.sv]
// sac_div: signed 32-bit divider, truncating toward zero, one quotient bit per cycle
// on magnitudes with a sign fix at the end. Depends on sac_pkg.
`timescale 1ns / 1ps

module sac_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sac_pkg::DATA_W-1:0] i_dividend,
    input  logic [sac_pkg::DATA_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [sac_pkg::DATA_W-1:0] o_quotient
);

    localparam int W     = sac_pkg::DATA_W;
    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [W-1:0]     r_q;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dsr;

    logic [W:0]   shifted;
    logic         take;
    logic [W:0]   diff;

    always_comb begin
        shifted = {r_rem, r_q[W-1]};
        diff    = shifted - {1'b0, r_dsr};
        take    = (shifted >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_dividend[W-1] ^ i_divisor[W-1];
                r_q    <= i_dividend[W-1] ? (W'(0) - i_dividend) : i_dividend;
                r_dsr  <= i_divisor[W-1] ? (W'(0) - i_divisor) : i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_q   <= {r_q[W-2:0], take};
                r_rem <= take ? diff[W-1:0] : shifted[W-1:0];
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    // the minimum value over minus one wraps back to the minimum value, with no saturation
    assign o_quotient = r_neg ? (W'(0) - r_q) : r_q;

endmodule

[sv/stack_alu_calculator.sv]
// stack_alu_calculator: reverse-Polish calculator; stack in a synchronous RAM,
// sequencer, ALU and iterative divider. Depends on sac_pkg, sac_stack_ram, sac_div.
// Push, unused code, full or too-few error go straight to the output stage; pop reads the
// top entry; add/sub/mul and divide by zero read two entries; divide also runs the divider.
// Throughput: one request at a time; the next is taken the cycle after its predecessor's
// result is registered. Reset (sync, active low) empties the stack; RAM is not cleared.
`timescale 1ns / 1ps

module stack_alu_calculator #(
    parameter int STACK_DEPTH = sac_pkg::STACK_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] func, [34:3] push_value, rest zero
    input  logic [sac_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] result_value, [39:32] depth, [41:40] status, rest zero
    output logic [sac_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int W  = sac_pkg::DATA_W;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_DIV,
        S_FIN
    } t_state;

    t_state                          r_state;
    logic [CW-1:0]                   r_depth;
    logic [sac_pkg::FUNC_W-1:0]      r_func;
    logic [W-1:0]                    r_a;
    logic [W-1:0]                    r_res;
    logic [sac_pkg::STATUS_W-1:0]    r_status;
    logic                            r_out_valid;
    logic [W-1:0]                    r_out_value;
    logic [sac_pkg::DEPTH_W-1:0]     r_out_depth;
    logic [sac_pkg::STATUS_W-1:0]    r_out_status;

    logic [sac_pkg::FUNC_W-1:0] in_func;
    logic [W-1:0]               in_value;
    logic                       accept;
    logic                       full;
    logic [CW-1:0]              dm1;
    logic [CW-1:0]              dm2;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [W-1:0]  ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [W-1:0]  ram_rdata;

    logic          div_start;
    logic          div_done;
    logic [W-1:0]  div_quot;
    logic [W-1:0]  alu_res;

    assign in_func  = s_axis_tdata[sac_pkg::FUNC_W-1:0];
    assign in_value = s_axis_tdata[sac_pkg::FUNC_W +: W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = (r_depth >= CW'(STACK_DEPTH));
    assign dm1           = r_depth - CW'(1);
    assign dm2           = r_depth - CW'(2);

    // a is the top entry (held), b arrives from the RAM in S_RD_B
    always_comb begin
        case (r_func)
            sac_pkg::FN_ADD: alu_res = r_a + ram_rdata;
            sac_pkg::FN_SUB: alu_res = r_a - ram_rdata;
            sac_pkg::FN_MUL: alu_res = r_a * ram_rdata;
            default:         alu_res = '0;
        endcase
    end

    assign div_start = (r_state == S_RD_B) && (r_func == sac_pkg::FN_DIV)
                       && (ram_rdata != '0);

    // stack port control; writes land before the next request can read
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = dm1[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = dm2[AW-1:0];
        ram_wdata = alu_res;
        case (r_state)
            S_IDLE: begin
                ram_re = accept;
                if (accept && in_func == sac_pkg::FN_PUSH && !full) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_depth[AW-1:0];
                    ram_wdata = in_value;
                end
            end
            S_RD_A: begin
                ram_re    = 1'b1;
                ram_raddr = dm2[AW-1:0];
            end
            S_RD_B: begin
                ram_we = (r_func != sac_pkg::FN_DIV);
            end
            S_DIV: begin
                ram_we    = div_done;
                ram_wdata = div_quot;
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_FIN handles the output register itself
            if (m_axis_tready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func   <= in_func;
                        r_res    <= '0;
                        r_status <= sac_pkg::ST_OK;
                        r_state  <= S_FIN;
                        case (in_func)
                            sac_pkg::FN_PUSH: begin
                                if (full) begin
                                    r_status <= sac_pkg::ST_FULL;
                                end else begin
                                    r_depth <= r_depth + CW'(1);
                                end
                            end
                            sac_pkg::FN_POP: begin
                                if (r_depth == '0) begin
                                    r_status <= sac_pkg::ST_FEW;
                                end else begin
                                    r_state <= S_RD_A;
                                end
                            end
                            sac_pkg::FN_ADD, sac_pkg::FN_SUB,
                            sac_pkg::FN_MUL, sac_pkg::FN_DIV: begin
                                if (r_depth < CW'(2)) begin
                                    r_status <= sac_pkg::ST_FEW;
                                end else begin
                                    r_state <= S_RD_A;
                                end
                            end
                            default: begin
                                r_status <= sac_pkg::ST_OK;
                            end
                        endcase
                    end
                end
                S_RD_A: begin
                    r_a <= ram_rdata;
                    if (r_func == sac_pkg::FN_POP) begin
                        r_res   <= ram_rdata;
                        r_depth <= dm1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_RD_B;
                    end
                end
                S_RD_B: begin
                    if (r_func != sac_pkg::FN_DIV) begin
                        r_res   <= alu_res;
                        r_depth <= dm1;
                        r_state <= S_FIN;
                    end else if (ram_rdata == '0) begin
                        r_status <= sac_pkg::ST_DIV0;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res   <= div_quot;
                        r_depth <= dm1;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold here while the previous result is still unread
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_res;
                        r_out_depth  <= sac_pkg::DEPTH_W'(r_depth);
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    sac_stack_ram #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    sac_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(r_a),
        .i_divisor (ram_rdata),
        .o_done    (div_done),
        .o_quotient(div_quot)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(sac_pkg::M_TDATA_W - W - sac_pkg::DEPTH_W - sac_pkg::STATUS_W)'(0),
                            r_out_status, r_out_depth, r_out_value};

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CW'(STACK_DEPTH))
        else $error("stack count beyond capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished while not awaited");

    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == sac_pkg::ST_FULL)
            |-> (r_out_depth == sac_pkg::DEPTH_W'(STACK_DEPTH)))
        else $error("stack full reported at wrong depth");

endmodule

[dv/stack_alu_calculator_test.sv]
// stack_alu_calculator_test: self-checking stream testbench for the stack ALU calculator.
// Directed command table, then weighted random command sequences, mostly checked against
// an in-bench stack model. Depends on sac_pkg and stack_alu_calculator.
`timescale 1ns / 1ps

module stack_alu_calculator_test;

    localparam int STACK_SLOTS = sac_pkg::STACK_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam logic [sac_pkg::FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [sac_pkg::FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [sac_pkg::DATA_W-1:0]   value;
        logic [sac_pkg::DEPTH_W-1:0]  depth;
        logic [sac_pkg::STATUS_W-1:0] status;
    } t_calc_result;

    typedef struct {
        logic [sac_pkg::FUNC_W-1:0] fn;
        logic [sac_pkg::DATA_W-1:0] operand;
        bit                         typed;
        t_calc_result               want;
    } t_opening_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    // [2:0] func, [34:3] push_value, rest zero
    logic [sac_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // [31:0] result_value, [39:32] depth, [41:40] status, rest zero
    logic [sac_pkg::M_TDATA_W-1:0] m_axis_tdata;

    logic [sac_pkg::DATA_W-1:0] operand_stack [STACK_SLOTS];
    int                         stack_level;
    t_calc_result               pending_results [$];
    t_opening_row               opening_rows [$];
    int                         mismatches = 0;
    int unsigned                stalled_cycles = 0;
    bit                         bursts_on;

    stack_alu_calculator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stack model: applies one command, returns the result the block should report.
    function automatic t_calc_result rpn_execute(input logic [sac_pkg::FUNC_W-1:0] fn,
                                                 input logic [sac_pkg::DATA_W-1:0] operand);
        t_calc_result               r;
        logic [sac_pkg::DATA_W-1:0] lhs, rhs, mag_l, mag_r, outcome;
        r = '{value: '0, depth: '0, status: sac_pkg::ST_OK};
        outcome = '0;
        if (fn == sac_pkg::FN_PUSH) begin
            if (stack_level >= STACK_SLOTS) begin
                r.status = sac_pkg::ST_FULL;
            end else begin
                operand_stack[stack_level] = operand;
                stack_level++;
            end
        end else if (fn == sac_pkg::FN_POP) begin
            if (stack_level < 1) begin
                r.status = sac_pkg::ST_FEW;
            end else begin
                r.value = operand_stack[stack_level-1];
                stack_level--;
            end
        end else if (fn == sac_pkg::FN_ADD || fn == sac_pkg::FN_SUB ||
                     fn == sac_pkg::FN_MUL || fn == sac_pkg::FN_DIV) begin
            if (stack_level < 2) begin
                r.status = sac_pkg::ST_FEW;
            end else begin
                // top of stack is the left operand
                lhs = operand_stack[stack_level-1];
                rhs = operand_stack[stack_level-2];
                if (fn == sac_pkg::FN_DIV && rhs == '0) begin
                    r.status = sac_pkg::ST_DIV0;
                end else begin
                    if (fn == sac_pkg::FN_ADD) begin
                        outcome = lhs + rhs;
                    end else if (fn == sac_pkg::FN_SUB) begin
                        outcome = lhs - rhs;
                    end else if (fn == sac_pkg::FN_MUL) begin
                        outcome = lhs * rhs;
                    end else begin
                        // magnitudes, then sign: truncates toward zero, min / -1 wraps
                        mag_l = lhs[sac_pkg::DATA_W-1] ? -lhs : lhs;
                        mag_r = rhs[sac_pkg::DATA_W-1] ? -rhs : rhs;
                        outcome = mag_l / mag_r;
                        if (lhs[sac_pkg::DATA_W-1] ^ rhs[sac_pkg::DATA_W-1]) outcome = -outcome;
                    end
                    stack_level--;
                    operand_stack[stack_level-1] = outcome;
                    r.value = outcome;
                end
            end
        end
        r.depth = stack_level[sac_pkg::DEPTH_W-1:0];
        return r;
    endfunction

    function automatic logic [sac_pkg::DATA_W-1:0] pick_operand();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return $urandom;
        if (sel < 8) return sac_pkg::DATA_W'($signed($urandom_range(0, 20)) - 10);
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // Mostly meaningful commands for the current depth, a little noise.
    function automatic logic [sac_pkg::FUNC_W-1:0] pick_command();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 4) return ($urandom_range(0, 1) != 0) ? FN_SPARE_LO : FN_SPARE_HI;
        if (stack_level < 2 && sel < 75) return sac_pkg::FN_PUSH;
        if (sel < 48) return sac_pkg::FN_PUSH;
        if (sel < 58) return sac_pkg::FN_POP;
        if (sel < 69) return sac_pkg::FN_ADD;
        if (sel < 80) return sac_pkg::FN_SUB;
        if (sel < 90) return sac_pkg::FN_MUL;
        return sac_pkg::FN_DIV;
    endfunction

    // Entered and left at a falling edge; predicts at the accepting rising edge.
    task automatic issue_command(input logic [sac_pkg::FUNC_W-1:0] fn,
                                 input logic [sac_pkg::DATA_W-1:0] operand,
                                 input bit typed, input t_calc_result want);
        t_calc_result predicted;
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(sac_pkg::S_TDATA_W-sac_pkg::FUNC_W-sac_pkg::DATA_W){1'b0}},
                          operand, fn};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = rpn_execute(fn, operand);
        pending_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_calc_result seen, wanted;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.value  = m_axis_tdata[sac_pkg::DATA_W-1:0];
            seen.depth  = m_axis_tdata[sac_pkg::DATA_W +: sac_pkg::DEPTH_W];
            seen.status = m_axis_tdata[sac_pkg::DATA_W+sac_pkg::DEPTH_W +: sac_pkg::STATUS_W];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value %h depth %0d status %0d",
                         $time, seen.value, seen.depth, seen.status);
                mismatches++;
            end else begin
                wanted = pending_results.pop_front();
                if (seen.value !== wanted.value || seen.depth !== wanted.depth ||
                    seen.status !== wanted.status) begin
                    $display("%0t: expected %h/%0d/%0d, got %h/%0d/%0d (value/depth/status)",
                             $time, wanted.value, wanted.depth, wanted.status,
                             seen.value, seen.depth, seen.status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cycles without any request or result moving.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side back-pressure in bursts.
    initial begin
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (bursts_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
        end
    end

    initial begin
        t_opening_row row;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        stack_level    = 0;
        bursts_on      = 1'b1;

        // from empty: underflows, extremes, divide by zero, min / -1, spare codes
        opening_rows.push_back('{sac_pkg::FN_POP,  32'h0, 1'b1, '{32'h0, 8'd0, sac_pkg::ST_FEW}});
        opening_rows.push_back('{sac_pkg::FN_ADD,  32'h0, 1'b1, '{32'h0, 8'd0, sac_pkg::ST_FEW}});
        opening_rows.push_back('{sac_pkg::FN_PUSH, 32'h7fff_ffff, 1'b1,
                                 '{32'h0, 8'd1, sac_pkg::ST_OK}});
        opening_rows.push_back('{sac_pkg::FN_DIV,  32'h0, 1'b1, '{32'h0, 8'd1, sac_pkg::ST_FEW}});
        opening_rows.push_back('{sac_pkg::FN_PUSH, 32'h8000_0000, 1'b1,
                                 '{32'h0, 8'd2, sac_pkg::ST_OK}});
        opening_rows.push_back('{sac_pkg::FN_ADD,  32'h0, 1'b0, '0});
        opening_rows.push_back('{sac_pkg::FN_PUSH, 32'h0, 1'b1, '{32'h0, 8'd2, sac_pkg::ST_OK}});
        opening_rows.push_back('{sac_pkg::FN_PUSH, 32'h5, 1'b1, '{32'h0, 8'd3, sac_pkg::ST_OK}});
        opening_rows.push_back('{sac_pkg::FN_DIV,  32'h0, 1'b1,
                                 '{32'h0, 8'd3, sac_pkg::ST_DIV0}});
        opening_rows.push_back('{sac_pkg::FN_POP,  32'h0, 1'b1, '{32'h5, 8'd2, sac_pkg::ST_OK}});
        opening_rows.push_back('{sac_pkg::FN_MUL,  32'h0, 1'b0, '0});
        opening_rows.push_back('{sac_pkg::FN_PUSH, 32'hffff_ffff, 1'b0, '0});
        opening_rows.push_back('{sac_pkg::FN_PUSH, 32'h8000_0000, 1'b0, '0});
        opening_rows.push_back('{sac_pkg::FN_DIV,  32'h0, 1'b1,
                                 '{32'h8000_0000, 8'd2, sac_pkg::ST_OK}});
        opening_rows.push_back('{FN_SPARE_LO, 32'h0, 1'b1, '{32'h0, 8'd2, sac_pkg::ST_OK}});
        opening_rows.push_back('{FN_SPARE_HI, 32'hffff_ffff, 1'b1,
                                 '{32'h0, 8'd2, sac_pkg::ST_OK}});
        opening_rows.push_back('{sac_pkg::FN_PUSH, 32'h2,         1'b0, '0});
        opening_rows.push_back('{sac_pkg::FN_PUSH, 32'hffff_fff9, 1'b0, '0});
        opening_rows.push_back('{sac_pkg::FN_DIV,  32'h0,         1'b0, '0});
        opening_rows.push_back('{sac_pkg::FN_SUB,  32'h0,         1'b0, '0});
        opening_rows.push_back('{sac_pkg::FN_MUL,  32'h0,         1'b0, '0});
        opening_rows.push_back('{sac_pkg::FN_PUSH, 32'h1234_5678, 1'b0, '0});
        opening_rows.push_back('{sac_pkg::FN_SUB,  32'h0,         1'b0, '0});
        opening_rows.push_back('{sac_pkg::FN_POP,  32'h0,         1'b0, '0});
        opening_rows.push_back('{sac_pkg::FN_SUB,  32'h0, 1'b1, '{32'h0, 8'd0, sac_pkg::ST_FEW}});

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_rows[k]) begin
            row = opening_rows[k];
            issue_command(row.fn, row.operand, row.typed, row.want);
        end

        // random mix, with calm stretches
        for (int n = 0; n < 700; n++) begin
            bursts_on = (n % 200) < 140;
            issue_command(pick_command(), pick_operand(), 1'b0, '0);
        end
        bursts_on = 1'b1;
        hold_until_drained();

        // fill to the top, overflow, drain to empty, underflow
        while (stack_level < STACK_SLOTS) begin
            issue_command(sac_pkg::FN_PUSH, pick_operand(), 1'b0, '0);
        end
        repeat (3) issue_command(sac_pkg::FN_PUSH, pick_operand(), 1'b0, '0);
        while (stack_level > 0) begin
            case ($urandom_range(0, 4))
                0:       issue_command(sac_pkg::FN_POP, pick_operand(), 1'b0, '0);
                1:       issue_command(sac_pkg::FN_ADD, pick_operand(), 1'b0, '0);
                2:       issue_command(sac_pkg::FN_SUB, pick_operand(), 1'b0, '0);
                3:       issue_command(sac_pkg::FN_MUL, pick_operand(), 1'b0, '0);
                default: issue_command(sac_pkg::FN_DIV, pick_operand(), 1'b0, '0);
            endcase
        end
        repeat (2) issue_command(sac_pkg::FN_POP, pick_operand(), 1'b0, '0);
        hold_until_drained();

        // final stretch starts with bursts, then runs without idling on either side
        for (int n = 0; n < 750; n++) begin
            bursts_on = n < 400;
            issue_command(pick_command(), pick_operand(), 1'b0, '0);
        end
        hold_until_drained();
        repeat (50) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
